>>> hdl/tvsp_pkg.sv
// Shared types and constants of the TLV varint stream parser.
`timescale 1ns / 1ps

package tvsp_pkg;

  localparam logic [3:0] VarintMaxBytes = 4'd10;
  localparam logic [3:0] FixedLastByte  = 4'd7;
  localparam logic [5:0] MinFieldIdReset = 6'd1;

  localparam logic [1:0] EV_END     = 2'd0;
  localparam logic [1:0] EV_SCALAR  = 2'd1;
  localparam logic [1:0] EV_LEN_HDR = 2'd2;
  localparam logic [1:0] EV_PAYLOAD = 2'd3;

  localparam logic [1:0] WT_UNSIGNED = 2'd0;
  localparam logic [1:0] WT_SIGNED   = 2'd1;
  localparam logic [1:0] WT_LENGTH   = 2'd2;
  localparam logic [1:0] WT_FIXED64  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ORDER  = 2'd1;
  localparam logic [1:0] ST_VARINT = 2'd2;
  localparam logic [1:0] ST_TRUNC  = 2'd3;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [5:0]  tag_id;
    logic [1:0]  tag_type;
    logic [63:0] field_value;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic        message_end;
    logic [1:0]  status;
  } res_t;

  // bit offset of varint group n, modulo 64
  function automatic logic [5:0] varint_shift(input logic [3:0] count);
    logic [6:0] prod;
    prod = 7'(count) * 7'd7;
    return prod[5:0];
  endfunction

endpackage

>>> hdl/tvsp_parse.sv
// Parse state and per-byte decode of the TLV varint stream parser.
`timescale 1ns / 1ps

module tvsp_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [5:0]        min_tag_id,
  input  logic              step_en,
  input  logic [7:0]        data_byte,
  input  logic              final_byte,
  output logic              have,
  output tvsp_pkg::res_t    res
);

  typedef enum logic [2:0] {
    PH_KEY     = 3'd0,
    PH_VARINT  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_FIXED   = 3'd5
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [5:0]  cur_id_r, cur_id_nxt;
  logic [1:0]  cur_type_r, cur_type_nxt;
  logic [5:0]  prev_id_r, prev_id_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  count_r, count_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic [1:0]  err_r, err_nxt;

  logic [5:0]  key_id;
  logic [1:0]  key_type;
  logic [6:0]  low7;
  logic [63:0] acc_var;
  logic [63:0] acc_fix;
  logic [63:0] zz_val;
  logic [15:0] len_full;
  logic [15:0] remain_dec;

  assign key_id     = data_byte[7:2];
  assign key_type   = data_byte[1:0];
  assign low7       = data_byte[6:0];
  assign acc_var    = acc_r | ({57'd0, low7} << tvsp_pkg::varint_shift(count_r));
  assign acc_fix    = acc_r | ({56'd0, data_byte} << {count_r[2:0], 3'b000});
  assign zz_val     = {1'b0, acc_var[63:1]} ^ {64{acc_var[0]}};
  assign len_full   = {data_byte, remain_r[7:0]};
  assign remain_dec = remain_r - 16'd1;

  always_comb begin
    phase_nxt    = phase_r;
    cur_id_nxt   = cur_id_r;
    cur_type_nxt = cur_type_r;
    prev_id_nxt  = prev_id_r;
    acc_nxt      = acc_r;
    count_nxt    = count_r;
    remain_nxt   = remain_r;
    err_nxt      = err_r;
    have         = 1'b0;
    res          = '0;

    if (err_r == tvsp_pkg::ST_OK) begin
      unique case (phase_r)
        PH_KEY: begin
          if (key_id < min_tag_id || key_id < prev_id_r) begin
            err_nxt = tvsp_pkg::ST_ORDER;
          end else begin
            cur_id_nxt   = key_id;
            cur_type_nxt = key_type;
            prev_id_nxt  = key_id;
            acc_nxt      = '0;
            count_nxt    = '0;
            remain_nxt   = '0;
            unique case (key_type)
              tvsp_pkg::WT_UNSIGNED,
              tvsp_pkg::WT_SIGNED:  phase_nxt = PH_VARINT;
              tvsp_pkg::WT_LENGTH:  phase_nxt = PH_LEN_LO;
              tvsp_pkg::WT_FIXED64: phase_nxt = PH_FIXED;
              default:              phase_nxt = PH_FIXED;
            endcase
          end
        end
        PH_VARINT: begin
          if (count_r >= tvsp_pkg::VarintMaxBytes ||
              (count_r == tvsp_pkg::VarintMaxBytes - 4'd1 && data_byte > 8'd1)) begin
            err_nxt = tvsp_pkg::ST_VARINT;
          end else if (data_byte[7]) begin
            acc_nxt   = acc_var;
            count_nxt = count_r + 4'd1;
          end else if (count_r != 4'd0 && low7 == 7'd0) begin
            acc_nxt = acc_var;
            err_nxt = tvsp_pkg::ST_VARINT;
          end else begin
            have            = 1'b1;
            res.event_res   = tvsp_pkg::EV_SCALAR;
            res.tag_id      = cur_id_r;
            res.tag_type    = cur_type_r;
            res.field_value = (cur_type_r == tvsp_pkg::WT_SIGNED) ? zz_val : acc_var;
            phase_nxt       = PH_KEY;
            count_nxt       = '0;
            acc_nxt         = '0;
          end
        end
        PH_LEN_LO: begin
          remain_nxt = {8'd0, data_byte};
          phase_nxt  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          remain_nxt         = len_full;
          have               = 1'b1;
          res.event_res      = tvsp_pkg::EV_LEN_HDR;
          res.tag_id         = cur_id_r;
          res.tag_type       = cur_type_r;
          res.payload_length = len_full;
          if (len_full == 16'd0) begin
            res.payload_last = 1'b1;
            phase_nxt        = PH_KEY;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          remain_nxt       = remain_dec;
          have             = 1'b1;
          res.event_res    = tvsp_pkg::EV_PAYLOAD;
          res.tag_id       = cur_id_r;
          res.tag_type     = cur_type_r;
          res.payload_byte = data_byte;
          if (remain_dec == 16'd0) begin
            res.payload_last = 1'b1;
            phase_nxt        = PH_KEY;
          end
        end
        PH_FIXED: begin
          if (count_r >= tvsp_pkg::FixedLastByte) begin
            have            = 1'b1;
            res.event_res   = tvsp_pkg::EV_SCALAR;
            res.tag_id      = cur_id_r;
            res.tag_type    = cur_type_r;
            res.field_value = acc_fix;
            acc_nxt         = '0;
            count_nxt       = '0;
            phase_nxt       = PH_KEY;
          end else begin
            acc_nxt   = acc_fix;
            count_nxt = count_r + 4'd1;
          end
        end
        default: phase_nxt = PH_KEY;
      endcase
    end

    if (final_byte) begin
      if (err_nxt == tvsp_pkg::ST_OK && phase_nxt != PH_KEY) begin
        err_nxt = tvsp_pkg::ST_TRUNC;
      end
      have            = 1'b1;
      res.message_end = 1'b1;
      res.status      = err_nxt;
      phase_nxt       = PH_KEY;
      cur_id_nxt      = '0;
      cur_type_nxt    = '0;
      prev_id_nxt     = '0;
      acc_nxt         = '0;
      count_nxt       = '0;
      remain_nxt      = '0;
      err_nxt         = tvsp_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_KEY;
      cur_id_r   <= '0;
      cur_type_r <= '0;
      prev_id_r  <= '0;
      acc_r      <= '0;
      count_r    <= '0;
      remain_r   <= '0;
      err_r      <= tvsp_pkg::ST_OK;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      cur_id_r   <= cur_id_nxt;
      cur_type_r <= cur_type_nxt;
      prev_id_r  <= prev_id_nxt;
      acc_r      <= acc_nxt;
      count_r    <= count_nxt;
      remain_r   <= remain_nxt;
      err_r      <= err_nxt;
    end
  end

endmodule

>>> hdl/tlv_varint_stream_parser.sv
// Top level of the TLV varint stream parser: input register, decode, result register.
// Flow: a byte accepted into the input register is decoded from it; its result, if any, is
// registered in the result register as the byte advances, which out_stall can hold back.
// Throughput: one byte per cycle unless out_stall holds a full result register.
// Reset (synchronous, rst_n low): parse state cleared, both registers empty,
// minimum tag id back to 1.
`timescale 1ns / 1ps

module tlv_varint_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_res,
  output logic [5:0]  out_tag_id,
  output logic [1:0]  out_tag_type,
  output logic [63:0] out_field_value,
  output logic [15:0] out_payload_length,
  output logic [7:0]  out_payload_byte,
  output logic        out_payload_last,
  output logic        out_message_end,
  output logic [1:0]  out_status
);

  logic [5:0]     min_id_r;
  logic           in_v_r;
  logic [7:0]     in_byte_r;
  logic           in_final_r;
  logic           out_v_r;
  tvsp_pkg::res_t res_r;

  logic           have;
  tvsp_pkg::res_t res;
  logic           advance;
  logic           in_take;

  tvsp_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .min_tag_id   (min_id_r),
    .step_en      (advance),
    .data_byte    (in_byte_r),
    .final_byte   (in_final_r),
    .have         (have),
    .res          (res)
  );

  assign advance  = in_v_r && (!have || !out_v_r || !out_stall);
  assign in_stall = in_v_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_id_r <= tvsp_pkg::MinFieldIdReset;
      in_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        min_id_r <= cfg_wdata;
      end
      if (in_take) begin
        in_v_r <= 1'b1;
      end else if (advance) begin
        in_v_r <= 1'b0;
      end
      if (advance && have) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // hold payloads while their stage is stalled
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r  <= in_data_byte;
      in_final_r <= in_final_byte;
    end
    if (advance && have) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_v_r;
  assign out_event_res      = res_r.event_res;
  assign out_tag_id         = res_r.tag_id;
  assign out_tag_type       = res_r.tag_type;
  assign out_field_value    = res_r.field_value;
  assign out_payload_length = res_r.payload_length;
  assign out_payload_byte   = res_r.payload_byte;
  assign out_payload_last   = res_r.payload_last;
  assign out_message_end    = res_r.message_end;
  assign out_status         = res_r.status;

endmodule

>>> dv/tb.sv
// Testbench of the TLV varint stream parser: random and directed messages against a local decoder.
`timescale 1ns / 1ps

module tb;
  import tvsp_pkg::*;

  typedef enum logic [2:0] {
    PS_KEY, PS_VARINT, PS_LEN_LO, PS_LEN_HI, PS_PAYLOAD, PS_FIXED
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } byte_item_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [5:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_final_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_event_res;
  logic [5:0]  out_tag_id;
  logic [1:0]  out_tag_type;
  logic [63:0] out_field_value;
  logic [15:0] out_payload_length;
  logic [7:0]  out_payload_byte;
  logic        out_payload_last;
  logic        out_message_end;
  logic [1:0]  out_status;

  tlv_varint_stream_parser dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data_byte(in_data_byte),
    .in_final_byte(in_final_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_event_res(out_event_res),
    .out_tag_id(out_tag_id),
    .out_tag_type(out_tag_type),
    .out_field_value(out_field_value),
    .out_payload_length(out_payload_length),
    .out_payload_byte(out_payload_byte),
    .out_payload_last(out_payload_last),
    .out_message_end(out_message_end),
    .out_status(out_status)
  );

  byte_item_t   byte_queue[$];
  res_t         due_results[$];
  logic [7:0]   msg[$];
  int           n_mismatch = 0;
  int           gap_left = 0;
  int           stall_left = 0;
  logic         idle_on = 1'b1;

  logic [5:0]   cfg_min_id = MinFieldIdReset;
  parse_phase_t m_phase = PS_KEY;
  logic [5:0]   m_id = '0;
  logic [1:0]   m_type = '0;
  logic [5:0]   m_prev_id = '0;
  logic [63:0]  m_acc = '0;
  logic [3:0]   m_count = '0;
  logic [15:0]  m_remaining = '0;
  logic [1:0]   m_err = ST_OK;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic decode_byte(input logic [7:0] b, input logic fin);
    res_t       r;
    logic       have;
    logic [63:0] v;
    logic [6:0] low;
    logic [5:0] id;
    r = '0;
    have = 1'b0;
    if (m_err == ST_OK) begin
      case (m_phase)
        PS_KEY: begin
          id = b[7:2];
          if (id < cfg_min_id || id < m_prev_id) begin
            m_err = ST_ORDER;
          end else begin
            m_id = id;
            m_type = b[1:0];
            m_prev_id = id;
            m_acc = '0;
            m_count = '0;
            m_remaining = '0;
            case (b[1:0])
              WT_UNSIGNED, WT_SIGNED: m_phase = PS_VARINT;
              WT_LENGTH: m_phase = PS_LEN_LO;
              default: m_phase = PS_FIXED;
            endcase
          end
        end
        PS_VARINT: begin
          low = b[6:0];
          if (m_count >= VarintMaxBytes || (m_count == VarintMaxBytes - 4'd1 && b > 8'd1)) begin
            m_err = ST_VARINT;
          end else begin
            m_acc = m_acc | (64'(low) << ((int'(m_count) * 7) & 63));
            if (!b[7]) begin
              if (m_count > 0 && low == 7'd0) begin
                m_err = ST_VARINT;
              end else begin
                v = m_acc;
                if (m_type == WT_SIGNED) v = (v >> 1) ^ {64{v[0]}};
                have = 1'b1;
                r.event_res = EV_SCALAR;
                r.field_value = v;
                m_phase = PS_KEY;
                m_count = '0;
                m_acc = '0;
              end
            end else begin
              m_count = m_count + 4'd1;
            end
          end
        end
        PS_LEN_LO: begin
          m_remaining = {8'd0, b};
          m_phase = PS_LEN_HI;
        end
        PS_LEN_HI: begin
          m_remaining = {b, m_remaining[7:0]};
          have = 1'b1;
          r.event_res = EV_LEN_HDR;
          r.payload_length = m_remaining;
          if (m_remaining == 16'd0) begin
            r.payload_last = 1'b1;
            m_phase = PS_KEY;
          end else begin
            m_phase = PS_PAYLOAD;
          end
        end
        PS_PAYLOAD: begin
          m_remaining = m_remaining - 16'd1;
          have = 1'b1;
          r.event_res = EV_PAYLOAD;
          r.payload_byte = b;
          if (m_remaining == 16'd0) begin
            r.payload_last = 1'b1;
            m_phase = PS_KEY;
          end
        end
        PS_FIXED: begin
          m_acc = m_acc | (64'(b) << ((int'(m_count) * 8) & 63));
          if (m_count >= FixedLastByte) begin
            have = 1'b1;
            r.event_res = EV_SCALAR;
            r.field_value = m_acc;
            m_acc = '0;
            m_count = '0;
            m_phase = PS_KEY;
          end else begin
            m_count = m_count + 4'd1;
          end
        end
        default: m_phase = PS_KEY;
      endcase
    end
    if (have && m_err == ST_OK) begin
      r.tag_id = m_id;
      r.tag_type = m_type;
    end else begin
      have = 1'b0;
      r = '0;
    end
    if (fin) begin
      if (m_err == ST_OK && m_phase != PS_KEY) m_err = ST_TRUNC;
      r.message_end = 1'b1;
      r.status = m_err;
      have = 1'b1;
      m_phase = PS_KEY;
      m_id = '0;
      m_type = '0;
      m_prev_id = '0;
      m_acc = '0;
      m_count = '0;
      m_remaining = '0;
      m_err = ST_OK;
    end
    if (have) due_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    n_mismatch++;
    if (n_mismatch <= 50) $display("mismatch %s: got %0h want %0h", what, got, want);
  endtask

  task automatic check_result();
    res_t got;
    res_t want;
    got = {out_event_res, out_tag_id, out_tag_type, out_field_value, out_payload_length,
           out_payload_byte, out_payload_last, out_message_end, out_status};
    if (due_results.size() == 0) begin
      report_mismatch("unexpected result, event", got.event_res, '0);
    end else begin
      want = due_results.pop_front();
      if (got.event_res !== want.event_res)
        report_mismatch("event_res", got.event_res, want.event_res);
      if (got.tag_id !== want.tag_id)
        report_mismatch("tag_id", got.tag_id, want.tag_id);
      if (got.tag_type !== want.tag_type)
        report_mismatch("tag_type", got.tag_type, want.tag_type);
      if (got.field_value !== want.field_value)
        report_mismatch("field_value", got.field_value, want.field_value);
      if (got.payload_length !== want.payload_length)
        report_mismatch("payload_length", got.payload_length, want.payload_length);
      if (got.payload_byte !== want.payload_byte)
        report_mismatch("payload_byte", got.payload_byte, want.payload_byte);
      if (got.payload_last !== want.payload_last)
        report_mismatch("payload_last", got.payload_last, want.payload_last);
      if (got.message_end !== want.message_end)
        report_mismatch("message_end", got.message_end, want.message_end);
      if (got.status !== want.status)
        report_mismatch("status", got.status, want.status);
    end
  endtask

  always @(posedge clk) begin
    byte_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) decode_byte(in_data_byte, in_final_byte);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (byte_queue.size() > 0) begin
          it = byte_queue.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= it.data;
          in_final_byte <= it.fin;
          if (idle_on && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 8);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 7);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    int          n;
    v = {$urandom, $urandom};
    n = $urandom_range(0, 64);
    if (n < 64) v = v & ((64'd1 << n) - 64'd1);
    if ($urandom_range(0, 15) == 0) v = '1;
    return v;
  endfunction

  function automatic void put_varint(input logic [63:0] value);
    logic [63:0] v;
    logic [7:0]  g;
    v = value;
    do begin
      g = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 64'd0) g[7] = 1'b1;
      msg.push_back(g);
    end while (v != 64'd0);
  endfunction

  function automatic void put_field(input logic [5:0] id);
    logic [1:0]  wt;
    logic [63:0] v;
    int          len;
    wt = 2'($urandom_range(0, 3));
    msg.push_back({id, wt});
    case (wt)
      WT_UNSIGNED: put_varint(rand_value());
      WT_SIGNED: begin
        v = rand_value();
        if ($urandom_range(0, 1) == 1) v = -v;
        put_varint({v[62:0], 1'b0} ^ {64{v[63]}});
      end
      WT_LENGTH: begin
        len = ($urandom_range(0, 39) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 6);
        msg.push_back(8'(len));
        msg.push_back(8'(len >> 8));
        repeat (len) msg.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        case ($urandom_range(0, 5))
          0: v = '0;
          1: v = '1;
          default: v = rand_value();
        endcase
        repeat (8) begin
          msg.push_back(v[7:0]);
          v = v >> 8;
        end
      end
    endcase
  endfunction

  function automatic void flush_message(input int last_idx);
    int i;
    for (i = 0; i <= last_idx; i++) byte_queue.push_back('{msg[i], i == last_idx});
  endfunction

  function automatic void queue_message();
    int kind;
    int id;
    int last;
    msg.delete();
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(1, 12)) msg.push_back(8'($urandom_range(0, 255)));
      flush_message(msg.size() - 1);
    end else begin
      id = cfg_min_id + $urandom_range(0, (63 - cfg_min_id) / 2);
      last = id;
      repeat ($urandom_range(1, 5)) begin
        put_field(6'(id));
        last = id;
        if ($urandom_range(0, 3) != 0) id = id + $urandom_range(1, 6);
        if (id > 63) id = 63;
      end
      if (kind == 7) begin
        case ($urandom_range(0, 2))
          0: if (last > 0) begin
            msg.push_back({6'($urandom_range(0, last - 1)), 2'($urandom_range(0, 3))});
          end
          1: begin
            msg.push_back({6'(id), WT_UNSIGNED});
            repeat ($urandom_range(1, 9)) msg.push_back(8'($urandom_range(0, 127)) | 8'h80);
            msg.push_back(8'h00);
          end
          default: begin
            msg.push_back({6'(id), WT_SIGNED});
            repeat (9) msg.push_back(8'($urandom_range(0, 127)) | 8'h80);
            msg.push_back(8'($urandom_range(2, 255)));
          end
        endcase
        put_field(6'(id));
      end
      if (kind == 8 && msg.size() > 1) flush_message($urandom_range(0, msg.size() - 2));
      else flush_message(msg.size() - 1);
    end
  endfunction

  task automatic wait_idle();
    while (byte_queue.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int ph;
    int target;
    logic [5:0] new_min;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        wait_idle();
        case (ph)
          1: new_min = 6'd0;
          2: new_min = 6'd63;
          3: new_min = 6'($urandom_range(2, 62));
          default: new_min = MinFieldIdReset;
        endcase
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= new_min;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_min_id = new_min;
      end
      @(negedge clk);
      idle_on = (ph != 4);
      if (ph == 0) begin
        msg = '{8'h04, 8'h00};
        flush_message(1);
        msg = '{8'h05, 8'h01};
        flush_message(1);
        msg = '{8'h0A, 8'h00, 8'h00};
        flush_message(2);
        msg = '{8'h0E, 8'h01, 8'h00, 8'hAB};
        flush_message(3);
        msg = '{8'h04, 8'h80, 8'h00};
        flush_message(2);
        msg = '{8'h08, 8'h00, 8'h04};
        flush_message(2);
        msg = '{8'h07};
        flush_message(0);
        msg = '{8'h0A, 8'hFF, 8'hFF, 8'h00};
        flush_message(3);
        msg = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        flush_message(8);
      end
      case (ph)
        0: target = 450;
        1: target = 400;
        2: target = 250;
        3: target = 400;
        default: target = 300;
      endcase
      target = target + byte_queue.size();
      while (byte_queue.size() < target) queue_message();
    end
    wait_idle();
    repeat (10) @(posedge clk);
    if (n_mismatch == 0 && due_results.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
